// ===== src/sha384_pkg.sv =====
// types, constants and round functions shared by the sha-384 engine
package sha384_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic REQ_DATA   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned LEN_START   = 112;
  localparam int unsigned ROUNDS      = 80;

  // control from the sequencer to the round unit
  typedef struct packed {
    logic       load;   // copy chaining words into working vars
    logic       step;   // run one round
    logic [6:0] round;  // round number 0..79
    logic       fold;   // add working vars into chaining words
    logic       init;   // reload initial values
  } rnd_ctl_t;

  function automatic logic [63:0] ror64(input logic [63:0] v, input int unsigned n);
    ror64 = (v >> n) | (v << (64 - n));
  endfunction

  function automatic logic [63:0] init_word(input logic [2:0] i);
    case (i)
      3'd0: init_word = 64'hcbbb9d5dc1059ed8;
      3'd1: init_word = 64'h629a292a367cd507;
      3'd2: init_word = 64'h9159015a3070dd17;
      3'd3: init_word = 64'h152fecd8f70e5939;
      3'd4: init_word = 64'h67332667ffc00b31;
      3'd5: init_word = 64'h8eb44a8768581511;
      3'd6: init_word = 64'hdb0c2e0d64f98fa7;
      default: init_word = 64'h47b5481dbefa4fa4;
    endcase
  endfunction

  function automatic logic [63:0] round_const(input logic [6:0] i);
    logic [63:0] k [0:79];
    k = '{
      64'h428a2f98d728ae22,64'h7137449123ef65cd,64'hb5c0fbcfec4d3b2f,64'he9b5dba58189dbbc,
      64'h3956c25bf348b538,64'h59f111f1b605d019,64'h923f82a4af194f9b,64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242,64'h12835b0145706fbe,64'h243185be4ee4b28c,64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f,64'h80deb1fe3b1696b1,64'h9bdc06a725c71235,64'hc19bf174cf692694,
      64'he49b69c19ef14ad2,64'hefbe4786384f25e3,64'h0fc19dc68b8cd5b5,64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275,64'h4a7484aa6ea6e483,64'h5cb0a9dcbd41fbd4,64'h76f988da831153b5,
      64'h983e5152ee66dfab,64'ha831c66d2db43210,64'hb00327c898fb213f,64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2,64'hd5a79147930aa725,64'h06ca6351e003826f,64'h142929670a0e6e70,
      64'h27b70a8546d22ffc,64'h2e1b21385c26c926,64'h4d2c6dfc5ac42aed,64'h53380d139d95b3df,
      64'h650a73548baf63de,64'h766a0abb3c77b2a8,64'h81c2c92e47edaee6,64'h92722c851482353b,
      64'ha2bfe8a14cf10364,64'ha81a664bbc423001,64'hc24b8b70d0f89791,64'hc76c51a30654be30,
      64'hd192e819d6ef5218,64'hd69906245565a910,64'hf40e35855771202a,64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8,64'h1e376c085141ab53,64'h2748774cdf8eeb99,64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63,64'h4ed8aa4ae3418acb,64'h5b9cca4f7763e373,64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc,64'h78a5636f43172f60,64'h84c87814a1f0ab72,64'h8cc702081a6439ec,
      64'h90befffa23631e28,64'ha4506cebde82bde9,64'hbef9a3f7b2c67915,64'hc67178f2e372532b,
      64'hca273eceea26619c,64'hd186b8c721c0c207,64'heada7dd6cde0eb1e,64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba,64'h0a637dc5a2c898a6,64'h113f9804bef90dae,64'h1b710b35131c471b,
      64'h28db77f523047d84,64'h32caab7b40c72493,64'h3c9ebe0a15c9bebc,64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6,64'h597f299cfc657e2a,64'h5fcb6fab3ad6faec,64'h6c44198c4a475817};
    round_const = k[i];
  endfunction

endpackage

// ===== src/sha384_round.sv =====
// shared sha-512 round unit with working variables and chaining words
module sha384_round import sha384_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rnd_ctl_t    ctl,
  input  logic [63:0] w_in,
  input  logic [2:0]  rd_idx,
  output logic [63:0] rd_word
);

  logic [63:0] h_r [0:7];
  logic [63:0] v_r [0:7];
  logic [63:0] t1, t2, s1e, s0a, ch, maj;

  always_comb begin
    s1e = ror64(v_r[4], 14) ^ ror64(v_r[4], 18) ^ ror64(v_r[4], 41);
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    s0a = ror64(v_r[0], 28) ^ ror64(v_r[0], 34) ^ ror64(v_r[0], 39);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1  = v_r[7] + s1e + ch + round_const(ctl.round) + w_in;
    t2  = s0a + maj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      for (int i = 0; i < 8; i++) h_r[i] <= init_word(3'(i));
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (ctl.step) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign rd_word = h_r[rd_idx];

endmodule

// ===== src/sha384_sched.sv =====
// message schedule: 16-word sliding window loaded byte by byte
module sha384_sched import sha384_pkg::*; (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [6:0]  wr_addr,
  input  logic [7:0]  wr_byte,
  input  logic        step,
  input  logic        expand,
  output logic [63:0] w_out
);

  logic [63:0] w_r [0:15];
  logic [63:0] s0, s1, w_new;

  always_comb begin
    s1 = ror64(w_r[14], 19) ^ ror64(w_r[14], 61) ^ (w_r[14] >> 6);
    s0 = ror64(w_r[1], 1) ^ ror64(w_r[1], 8) ^ (w_r[1] >> 7);
    w_new = s1 + w_r[9] + s0 + w_r[0];
  end

  // first 16 rounds use loaded words, later rounds the expansion
  assign w_out = w_r[0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      w_r[wr_addr[6:3]][8*(7 - wr_addr[2:0]) +: 8] <= wr_byte;
    end else if (step) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= expand ? w_new : w_r[0];
    end
  end

endmodule

// ===== src/sha384_hash_engine.sv =====
// top level of the sha-384 engine: byte intake, padding sequencer, digest output
// A data transfer writes one byte; the transfer of the 128th byte of a block is
// followed by in_ready low for one load, 80 rounds on the single shared round
// unit and one fold. A finish transfer writes the pad and length bytes one per
// cycle (128 minus the buffered byte count, plus 128 more when the length spills
// into a second block), compresses each padded block the same way, then presents
// the six digest words through one output register, one per cycle while out_ready
// is high, and finally reloads the initial values. The round unit's one round per
// cycle sets the rate.
module sha384_hash_engine import sha384_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_PAD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [6:0]  fill_r, fill_nxt;
  logic [63:0] len_r, len_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic        fin_r, fin_nxt;     // block being compressed is the last one
  logic        marked_r, marked_nxt; // pad marker already written
  logic [2:0]  widx_r, widx_nxt;
  logic        ovalid_r, ovalid_nxt;
  out_item_t   odata_r, odata_nxt;

  rnd_ctl_t    ctl;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [63:0] w_cur, rd_word;
  logic        accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  sha384_sched u_sched (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r),
    .wr_byte (wr_byte),
    .step    (ctl.step),
    .expand  (1'b1),
    .w_out   (w_cur)
  );

  sha384_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .w_in    (w_cur),
    .rd_idx  (widx_r),
    .rd_word (rd_word)
  );

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    rnd_nxt    = rnd_r;
    fin_nxt    = fin_r;
    marked_nxt = marked_r;
    widx_nxt   = widx_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    ctl        = '0;
    ctl.round  = rnd_r;
    wr_en      = 1'b0;
    wr_byte    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_DATA) begin
            wr_en    = 1'b1;
            wr_byte  = in_data.data_byte;
            len_nxt  = len_r + 64'd8;
            fill_nxt = fill_r + 7'd1;
            if (fill_r == 7'(BLOCK_BYTES - 1)) begin
              fin_nxt   = 1'b0;
              state_nxt = S_LOAD;
            end
          end else begin
            marked_nxt = 1'b0;
            state_nxt  = S_PAD;
          end
        end
      end
      S_PAD: begin
        wr_en    = 1'b1;
        fill_nxt = fill_r + 7'd1;
        if (!marked_r) begin
          wr_byte    = PAD_MARKER;
          marked_nxt = 1'b1;
          // spill when marker lands at or past the length field start
          fin_nxt    = (fill_r < 7'(LEN_START));
        end else if (fin_r && fill_r >= 7'd120) begin
          // length bytes go most significant first
          wr_byte = len_r[{~fill_r[2:0], 3'b000} +: 8];
        end else begin
          wr_byte = 8'h00;
        end
        if (fill_r == 7'(BLOCK_BYTES - 1)) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        ctl.load  = 1'b1;
        rnd_nxt   = '0;
        state_nxt = S_RND;
      end
      S_RND: begin
        ctl.step = 1'b1;
        rnd_nxt  = rnd_r + 7'd1;
        if (rnd_r == 7'(ROUNDS - 1)) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        ctl.fold = 1'b1;
        if (!marked_r) begin
          state_nxt = S_IDLE;
        end else if (fin_r) begin
          widx_nxt  = '0;
          state_nxt = S_OUT;
        end else begin
          fin_nxt   = 1'b1;
          state_nxt = S_PAD;
        end
      end
      S_OUT: begin
        if (!ovalid_r || out_ready) begin
          if (widx_r == 3'd6) begin
            ovalid_nxt = 1'b0;
            ctl.init   = 1'b1;
            len_nxt    = '0;
            marked_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end else begin
            ovalid_nxt            = 1'b1;
            odata_nxt.digest_word = rd_word;
            odata_nxt.word_index  = widx_r;
            odata_nxt.last_word   = (widx_r == 3'd5);
            widx_nxt              = widx_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r != S_OUT && ovalid_r && out_ready) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      len_r    <= '0;
      rnd_r    <= '0;
      fin_r    <= 1'b0;
      marked_r <= 1'b0;
      widx_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      len_r    <= len_nxt;
      rnd_r    <= rnd_nxt;
      fin_r    <= fin_nxt;
      marked_r <= marked_nxt;
      widx_r   <= widx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
  end

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the sha-384 engine: random, all-zero and all-ones byte streams with finish requests
module tb_top import sha384_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  sha384_hash_engine i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  localparam int IDLE_LIMIT = 8000;

  in_item_t  pending_items[$];
  out_item_t expected_words[$];
  int        mismatch_count;
  int        idle_cycles;
  int        queued_count;
  int        in_count;
  bit        hold_off_req;
  bit        sender_pause;

  // driver and receiver state
  int        send_gap;
  bit        noisy_sender;
  bit        in_done;
  int        stall_gap;
  int        hold_off_count;
  out_item_t want;

  // digest state of the predictor
  logic [63:0] hash_h[8];
  logic [7:0]  msg_block[128];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  localparam logic [63:0] H_INIT[8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};

  localparam logic [63:0] K_TAB[80] = '{
    64'h428a2f98d728ae22,64'h7137449123ef65cd,64'hb5c0fbcfec4d3b2f,64'he9b5dba58189dbbc,
    64'h3956c25bf348b538,64'h59f111f1b605d019,64'h923f82a4af194f9b,64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242,64'h12835b0145706fbe,64'h243185be4ee4b28c,64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f,64'h80deb1fe3b1696b1,64'h9bdc06a725c71235,64'hc19bf174cf692694,
    64'he49b69c19ef14ad2,64'hefbe4786384f25e3,64'h0fc19dc68b8cd5b5,64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275,64'h4a7484aa6ea6e483,64'h5cb0a9dcbd41fbd4,64'h76f988da831153b5,
    64'h983e5152ee66dfab,64'ha831c66d2db43210,64'hb00327c898fb213f,64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2,64'hd5a79147930aa725,64'h06ca6351e003826f,64'h142929670a0e6e70,
    64'h27b70a8546d22ffc,64'h2e1b21385c26c926,64'h4d2c6dfc5ac42aed,64'h53380d139d95b3df,
    64'h650a73548baf63de,64'h766a0abb3c77b2a8,64'h81c2c92e47edaee6,64'h92722c851482353b,
    64'ha2bfe8a14cf10364,64'ha81a664bbc423001,64'hc24b8b70d0f89791,64'hc76c51a30654be30,
    64'hd192e819d6ef5218,64'hd69906245565a910,64'hf40e35855771202a,64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8,64'h1e376c085141ab53,64'h2748774cdf8eeb99,64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63,64'h4ed8aa4ae3418acb,64'h5b9cca4f7763e373,64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc,64'h78a5636f43172f60,64'h84c87814a1f0ab72,64'h8cc702081a6439ec,
    64'h90befffa23631e28,64'ha4506cebde82bde9,64'hbef9a3f7b2c67915,64'hc67178f2e372532b,
    64'hca273eceea26619c,64'hd186b8c721c0c207,64'heada7dd6cde0eb1e,64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba,64'h0a637dc5a2c898a6,64'h113f9804bef90dae,64'h1b710b35131c471b,
    64'h28db77f523047d84,64'h32caab7b40c72493,64'h3c9ebe0a15c9bebc,64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6,64'h597f299cfc657e2a,64'h5fcb6fab3ad6faec,64'h6c44198c4a475817};

  function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  task automatic compress_block();
    logic [63:0] w[80];
    logic [63:0] v[8];
    logic [63:0] t1, t2;
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 8; j++) w[i] = {w[i][55:0], msg_block[i*8+j]};
    for (int i = 16; i < 80; i++)
      w[i] = (rotr(w[i-2], 19) ^ rotr(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
           + (rotr(w[i-15], 1) ^ rotr(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
    v = hash_h;
    for (int i = 0; i < 80; i++) begin
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  task automatic restart_digest();
    hash_h = H_INIT;
    block_fill = 0;
    msg_bits = '0;
  endtask

  // advance the predictor by one accepted input transfer
  task automatic hash_absorb(input in_item_t item);
    out_item_t word;
    if (item.req_type == REQ_DATA) begin
      msg_block[block_fill] = item.data_byte;
      block_fill++;
      msg_bits += 64'd8;
      if (block_fill == BLOCK_BYTES) begin
        compress_block();
        block_fill = 0;
      end
    end else begin
      msg_block[block_fill] = PAD_MARKER;
      block_fill++;
      if (block_fill > LEN_START) begin
        while (block_fill < BLOCK_BYTES) msg_block[block_fill++] = 8'h00;
        compress_block();
        block_fill = 0;
      end
      while (block_fill < 120) msg_block[block_fill++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[120+i] = msg_bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 6; i++) begin
        word.digest_word = hash_h[i];
        word.word_index  = 3'(i);
        word.last_word   = (i == 5);
        expected_words.push_back(word);
      end
      restart_digest();
    end
  endtask

  task automatic queue_message(input int len, input int kind);
    in_item_t item;
    for (int i = 0; i < len; i++) begin
      item.req_type = REQ_DATA;
      case (kind)
        1: item.data_byte = 8'h00;
        2: item.data_byte = 8'hff;
        default: item.data_byte = 8'($urandom);
      endcase
      pending_items.push_back(item);
    end
    item.req_type  = REQ_FINISH;
    item.data_byte = 8'($urandom);
    pending_items.push_back(item);
    queued_count += len + 1;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // driver
  initial noisy_sender = 1'b1;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
      in_done = 1'b0;
    end else if (in_valid && !in_done) begin
      // hold the offered item
    end else begin
      in_done = 1'b0;
      if (sender_pause || pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
        send_gap <= noisy_sender ? gap_len() : 0;
      end
    end
  end

  // input transfers feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      hash_absorb(in_data);
      in_count++;
      in_done = 1'b1;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_gap <= 0;
      hold_off_count <= 0;
    end else if (hold_off_req && hold_off_count == 0) begin
      hold_off_count <= 1500;
      out_ready <= 1'b0;
    end else if (hold_off_count > 1) begin
      hold_off_count <= hold_off_count - 1;
      out_ready <= 1'b0;
    end else if (stall_gap > 0) begin
      if (hold_off_count == 1) hold_off_count <= 0;
      stall_gap <= stall_gap - 1;
      out_ready <= 1'b0;
    end else begin
      if (hold_off_count == 1) hold_off_count <= 0;
      out_ready <= 1'b1;
      stall_gap <= noisy_sender ? gap_len() : 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected digest word %h idx %0d", out_data.digest_word,
                   out_data.word_index);
      end else begin
        want = expected_words.pop_front();
        if (out_data !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d", want.digest_word,
                     want.word_index, want.last_word, out_data.digest_word,
                     out_data.word_index, out_data.last_word);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    hold_off_req = 1'b0;
    sender_pause = 1'b0;
    restart_digest();
    // empty message and a short all-zero one
    queue_message(0, 0);
    queue_message(3, 1);
    while (in_count < queued_count) @(posedge clk);
    // sender waits until every digest word has drained
    sender_pause = 1'b1;
    queue_message(112, 2);
    while (expected_words.size() != 0) @(posedge clk);
    @(negedge clk);
    sender_pause = 1'b0;
    // long receiver hold-off while the length spill message and a two-block one are offered
    hold_off_req = 1'b1;
    queue_message(239, 0);
    while (hold_off_count == 0) @(posedge clk);
    hold_off_req = 1'b0;
    while (in_count < queued_count || expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
